>>> rtl/core/rpd_pkg.sv
// Shared types and helpers for the RGB pixel doubler.
`default_nettype none

package rpd_pkg;

  localparam int unsigned PixW     = 32;
  localparam int unsigned NumRes   = 8;
  localparam int unsigned CntW     = 4;
  localparam int unsigned FmtW     = 3;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;
  localparam logic [FmtW-1:0] FmtReset = 3'd2;

  localparam logic [7:0]  Mask5  = 8'h1F;
  localparam logic [7:0]  Mask6  = 8'h3F;
  localparam logic [7:0]  Mask8  = 8'hFF;
  localparam logic [PixW-1:0] Mask24 = 32'h00FF_FFFF;

  typedef enum logic [FmtW-1:0] {
    FMT_DUP  = 3'd0,
    FMT_555  = 3'd1,
    FMT_565  = 3'd2,
    FMT_888  = 3'd3,
    FMT_8888 = 3'd4
  } fmt_e;

  // Full result set of one input, in output order.
  typedef struct packed {
    logic [CntW-1:0]             count;
    logic [NumRes-1:0][PixW-1:0] pix;
  } res_t;

  // Codes above the last format behave as 32-bit xRGB.
  function automatic fmt_e fmt_norm(input logic [FmtW-1:0] raw);
    fmt_e f;
    begin
      if (raw > FMT_8888) begin
        f = FMT_8888;
      end else begin
        f = fmt_e'(raw);
      end
      return f;
    end
  endfunction

  function automatic logic [PixW-1:0] pix_mask(input fmt_e f);
    logic [PixW-1:0] m;
    begin
      unique case (f)
        FMT_DUP:          m = {24'd0, Mask8};
        FMT_555, FMT_565: m = {16'd0, Mask8, Mask8};
        FMT_888:          m = Mask24;
        default:          m = '1;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rgb_pixel_doubler_interp.sv
// Top level of the 2x smoothing upscaler for packed RGB pixels.
// Each input transfer carries one column of two adjacent source rows. Once a
// row has a previous column, the next column makes that previous column emit
// four destination pixels (upper row: the pixel and its average with the
// right neighbor; lower row: the vertical and the diagonal average, or a copy
// of the upper row in the bottom row; the 8-bit mode only replicates), and the
// last column of a row additionally emits its own 2x2 duplicate, so one input
// causes zero, four or eight output transfers. Three averaging lanes work on
// the horizontal, vertical and diagonal pairs in the same cycle, a merging
// stage orders their results, and the whole list is captured in an eight-entry
// result buffer that the output port drains one pixel per cycle while
// out_ready_i is high, so the output port sets the rate. A new input is taken
// in the same cycle as the last buffered result leaves, so a steady stream
// runs without gaps. The pixel format register sits at byte address 0 of the
// APB-style port and should only be written while the block is idle.
`default_nettype none

module rgb_pixel_doubler_interp
  import rpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PixW-1:0]  upper_pixel_i,
  input  logic [PixW-1:0]  lower_pixel_i,
  input  logic             row_end_i,
  input  logic             bottom_row_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PixW-1:0]  out_pixel_o,
  output logic             dest_row_o,
  output logic             run_last_o
);

  localparam int unsigned IdxW = $clog2(NumRes);

  // Configuration register; the raw value is kept so that reads return it.
  logic [FmtW-1:0] fmt_q, fmt_d;
  logic            cfg_we;
  fmt_e            fmt;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[AddrW-1:2] == '0);
  assign fmt_d  = cfg_we ? pwdata[FmtW-1:0] : fmt_q;
  assign prdata = (paddr[AddrW-1:2] == '0) ? {{(DataW-FmtW){1'b0}}, fmt_q} : '0;
  assign fmt    = fmt_norm(fmt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtReset;
    end else begin
      fmt_q <= fmt_d;
    end
  end

  // Previous column of the current row.
  logic [PixW-1:0] prev_upper_q, prev_lower_q;
  logic            have_prev_q;
  logic            in_xfer;
  logic            out_xfer;

  // Result buffer: the whole list of one input and a read pointer into it.
  logic [NumRes-1:0][PixW-1:0] buf_q;
  logic [CntW-1:0]             rem_q, rem_d;
  logic [IdxW-1:0]             idx_q, idx_d;

  assign out_valid_o = (rem_q != '0);
  assign out_xfer    = out_valid_o && out_ready_i;
  // The buffer can be refilled as soon as its final entry is being taken.
  assign in_ready_o  = (rem_q == '0) || ((rem_q == CntW'(1)) && out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_upper_q <= '0;
      prev_lower_q <= '0;
      have_prev_q  <= 1'b0;
    end else if (in_xfer) begin
      prev_upper_q <= upper_pixel_i;
      prev_lower_q <= lower_pixel_i;
      have_prev_q  <= !row_end_i;
    end
  end

  // Three lanes: right neighbor, pixel below, lower-right pixel.
  logic [PixW-1:0] horiz, vert, diag;

  rpd_avg_lane u_lane_h (
    .fmt_i (fmt),
    .x_i   (prev_upper_q),
    .y_i   (upper_pixel_i),
    .avg_o (horiz)
  );

  rpd_avg_lane u_lane_v (
    .fmt_i (fmt),
    .x_i   (prev_upper_q),
    .y_i   (prev_lower_q),
    .avg_o (vert)
  );

  rpd_avg_lane u_lane_d (
    .fmt_i (fmt),
    .x_i   (prev_upper_q),
    .y_i   (lower_pixel_i),
    .avg_o (diag)
  );

  res_t res;

  rpd_merge u_merge (
    .fmt_i        (fmt),
    .have_prev_i  (have_prev_q),
    .row_end_i    (row_end_i),
    .bottom_row_i (bottom_row_i),
    .prev_upper_i (prev_upper_q),
    .upper_i      (upper_pixel_i),
    .lower_i      (lower_pixel_i),
    .horiz_i      (horiz),
    .vert_i       (vert),
    .diag_i       (diag),
    .res_o        (res)
  );

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (in_xfer) begin
      rem_d = res.count;
      idx_d = '0;
    end else if (out_xfer) begin
      rem_d = rem_q - CntW'(1);
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      buf_q <= res.pix;
    end
  end

  // Within each group of four the first two entries go to the upper row.
  assign out_pixel_o = buf_q[idx_q];
  assign dest_row_o  = idx_q[1];
  assign run_last_o  = (rem_q == CntW'(1));

endmodule

`default_nettype wire

>>> rtl/core/rpd_avg_lane.sv
// One averaging lane: per-channel floor average of two packed pixels.
`default_nettype none

module rpd_avg_lane
  import rpd_pkg::*;
(
  input  fmt_e            fmt_i,
  input  logic [PixW-1:0] x_i,
  input  logic [PixW-1:0] y_i,
  output logic [PixW-1:0] avg_o
);

  logic [5:0] r555, g555, b555;
  logic [5:0] r565, b565;
  logic [6:0] g565;
  logic [8:0] r888, g888, b888;

  assign r555 = {1'b0, x_i[14:10]} + {1'b0, y_i[14:10]};
  assign g555 = {1'b0, x_i[9:5]}   + {1'b0, y_i[9:5]};
  assign b555 = {1'b0, x_i[4:0]}   + {1'b0, y_i[4:0]};

  assign r565 = {1'b0, x_i[15:11]} + {1'b0, y_i[15:11]};
  assign g565 = {1'b0, x_i[10:5]}  + {1'b0, y_i[10:5]};
  assign b565 = {1'b0, x_i[4:0]}   + {1'b0, y_i[4:0]};

  assign r888 = {1'b0, x_i[23:16]} + {1'b0, y_i[23:16]};
  assign g888 = {1'b0, x_i[15:8]}  + {1'b0, y_i[15:8]};
  assign b888 = {1'b0, x_i[7:0]}   + {1'b0, y_i[7:0]};

  always_comb begin
    unique case (fmt_i)
      FMT_555: avg_o = {17'd0, r555[5:1], g555[5:1], b555[5:1]};
      FMT_565: avg_o = {16'd0, r565[5:1], g565[6:1], b565[5:1]};
      FMT_DUP, FMT_888, FMT_8888: begin
        avg_o = {8'd0, r888[8:1], g888[8:1], b888[8:1]};
      end
      default: avg_o = {8'd0, r888[8:1], g888[8:1], b888[8:1]};
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/rpd_merge.sv
// Merging stage: orders the lane results into the list of output pixels.
`default_nettype none

module rpd_merge
  import rpd_pkg::*;
(
  input  fmt_e            fmt_i,
  input  logic            have_prev_i,
  input  logic            row_end_i,
  input  logic            bottom_row_i,
  input  logic [PixW-1:0] prev_upper_i,
  input  logic [PixW-1:0] upper_i,
  input  logic [PixW-1:0] lower_i,
  input  logic [PixW-1:0] horiz_i,
  input  logic [PixW-1:0] vert_i,
  input  logic [PixW-1:0] diag_i,
  output res_t            res_o
);

  logic [PixW-1:0]        mask;
  logic [PixW-1:0]        prev_m;
  logic [PixW-1:0]        up_m;
  logic [PixW-1:0]        low_m;
  logic [3:0][PixW-1:0]   mid_grp;
  logic [3:0][PixW-1:0]   end_grp;

  assign mask   = pix_mask(fmt_i);
  assign prev_m = prev_upper_i & mask;
  assign up_m   = upper_i & mask;
  assign low_m  = ((fmt_i == FMT_DUP) || bottom_row_i) ? up_m : (lower_i & mask);

  // By index, groups are upper, upper, lower, lower; index 0 goes out first.
  always_comb begin
    if (fmt_i == FMT_DUP) begin
      mid_grp = {prev_m, prev_m, prev_m, prev_m};
    end else if (bottom_row_i) begin
      mid_grp = {horiz_i, prev_m, horiz_i, prev_m};
    end else begin
      mid_grp = {diag_i, vert_i, horiz_i, prev_m};
    end
    end_grp = {low_m, low_m, up_m, up_m};
  end

  always_comb begin
    res_o.pix   = '0;
    res_o.count = '0;
    if (have_prev_i) begin
      res_o.pix[3:0] = mid_grp;
      res_o.count    = CntW'(4);
      if (row_end_i) begin
        res_o.pix[7:4] = end_grp;
        res_o.count    = CntW'(8);
      end
    end else if (row_end_i) begin
      res_o.pix[3:0] = end_grp;
      res_o.count    = CntW'(4);
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_rgb_pixel_doubler_interp.sv
// Self-checking testbench for the RGB 2x smoothing upscaler.
`timescale 1ns / 100ps

module tb_rgb_pixel_doubler_interp;
  import rpd_pkg::*;

  // Byte address of the pixel format register on the APB-style port.
  localparam logic [AddrW-1:0] RegPixelFormat = '0;

  // Format codes above the last defined one; the block treats them as xRGB8888.
  localparam logic [FmtW-1:0] FmtSpareLo  = 3'd5;
  localparam logic [FmtW-1:0] FmtSpareMid = 3'd6;
  localparam logic [FmtW-1:0] FmtSpareHi  = 3'd7;

  localparam int unsigned MaxIdle     = 6;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned CycleLimit  = 200000;

  // One destination pixel as the output port presents it.
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            row;
    logic            last;
  } dest_pix_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [PixW-1:0]  upper_pixel_i = '0;
  logic [PixW-1:0]  lower_pixel_i = '0;
  logic             row_end_i = 1'b0;
  logic             bottom_row_i = 1'b0;

  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [PixW-1:0]  out_pixel_o;
  logic             dest_row_o;
  logic             run_last_o;

  // Shadow of the block: format register and the stored previous column.
  logic [FmtW-1:0]  fmt_shadow = FmtReset;
  logic [PixW-1:0]  prev_upper_shadow = '0;
  logic [PixW-1:0]  prev_lower_shadow = '0;
  logic             prev_valid_shadow = 1'b0;

  // Destination pixels still owed by the block, oldest first.
  dest_pix_t        pending_pix_q[$];

  int unsigned      error_cnt = 0;
  int unsigned      column_cnt = 0;
  int unsigned      pixel_cnt = 0;
  int unsigned      cycle_cnt = 0;

  // Sender bookkeeping. When the next transfer follows without a gap, valid
  // simply stays high and the payload is replaced at the acceptance edge.
  bit               idle_on = 1'b1;
  bit               valid_held = 1'b0;
  int unsigned      next_gap = 1;

  // Receiver stall bookkeeping; hold_off forces a long stall from its own process.
  int unsigned      stall_left = 0;
  logic             hold_off = 1'b0;

  rgb_pixel_doubler_interp u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .upper_pixel_i (upper_pixel_i),
    .lower_pixel_i (lower_pixel_i),
    .row_end_i     (row_end_i),
    .bottom_row_i  (bottom_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_pixel_o   (out_pixel_o),
    .dest_row_o    (dest_row_o),
    .run_last_o    (run_last_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // The run is aborted if it has not finished well past the slowest legal run.
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles, %0d pixels still pending",
             $time, cycle_cnt, pending_pix_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Floor average of one channel, left in place at its bit position.
  function automatic logic [PixW-1:0] chan_mean(input logic [PixW-1:0] x,
                                                input logic [PixW-1:0] y,
                                                input int unsigned sh,
                                                input logic [7:0] m);
    logic [8:0] a;
    logic [8:0] b;
    logic [8:0] s;
    a = 9'((x >> sh) & {24'd0, m});
    b = 9'((y >> sh) & {24'd0, m});
    s = (a + b) >> 1;
    return PixW'(s) << sh;
  endfunction

  // Per-channel average of two packed pixels; only channel bits survive.
  function automatic logic [PixW-1:0] blend_pix(input fmt_e f,
                                                input logic [PixW-1:0] x,
                                                input logic [PixW-1:0] y);
    case (f)
      FMT_555: return chan_mean(x, y, 10, Mask5) | chan_mean(x, y, 5, Mask5) |
                      chan_mean(x, y, 0, Mask5);
      FMT_565: return chan_mean(x, y, 11, Mask5) | chan_mean(x, y, 5, Mask6) |
                      chan_mean(x, y, 0, Mask5);
      default: return chan_mean(x, y, 16, Mask8) | chan_mean(x, y, 8, Mask8) |
                      chan_mean(x, y, 0, Mask8);
    endcase
  endfunction

  // Bits that a copied pixel keeps in each format.
  function automatic logic [PixW-1:0] copy_mask(input fmt_e f);
    case (f)
      FMT_DUP:          return 32'h0000_00FF;
      FMT_555, FMT_565: return 32'h0000_FFFF;
      FMT_888:          return 32'h00FF_FFFF;
      default:          return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic dest_pix_t dest_pix(input logic [PixW-1:0] pix, input logic row);
    dest_pix_t d;
    d.pix  = pix;
    d.row  = row;
    d.last = 1'b0;
    return d;
  endfunction

  // Works out every destination pixel that one accepted column causes and
  // appends them to the pending list, then updates the shadow state.
  task automatic upscale_column(input logic [PixW-1:0] up, input logic [PixW-1:0] lo,
                                input logic row_end, input logic bottom);
    fmt_e            f;
    logic [PixW-1:0] m;
    logic [PixW-1:0] b;
    logic [PixW-1:0] h;
    logic [PixW-1:0] low_src;
    dest_pix_t       grp[$];
    f = (fmt_shadow > FMT_8888) ? FMT_8888 : fmt_e'(fmt_shadow);
    m = copy_mask(f);
    b = prev_upper_shadow;
    if (prev_valid_shadow) begin
      if (f == FMT_DUP) begin
        // The 8-bit mode only replicates: a 2x2 block of the previous pixel.
        grp.push_back(dest_pix(b & m, 1'b0));
        grp.push_back(dest_pix(b & m, 1'b0));
        grp.push_back(dest_pix(b & m, 1'b1));
        grp.push_back(dest_pix(b & m, 1'b1));
      end else if (bottom) begin
        // In the last source row the lower output row repeats the upper one.
        h = blend_pix(f, b, up);
        grp.push_back(dest_pix(b & m, 1'b0));
        grp.push_back(dest_pix(h, 1'b0));
        grp.push_back(dest_pix(b & m, 1'b1));
        grp.push_back(dest_pix(h, 1'b1));
      end else begin
        grp.push_back(dest_pix(b & m, 1'b0));
        grp.push_back(dest_pix(blend_pix(f, b, up), 1'b0));
        grp.push_back(dest_pix(blend_pix(f, b, prev_lower_shadow), 1'b1));
        grp.push_back(dest_pix(blend_pix(f, b, lo), 1'b1));
      end
    end
    if (row_end) begin
      // The last column of a row is duplicated into both output rows.
      low_src = (f == FMT_DUP || bottom) ? up : lo;
      grp.push_back(dest_pix(up & m, 1'b0));
      grp.push_back(dest_pix(up & m, 1'b0));
      grp.push_back(dest_pix(low_src & m, 1'b1));
      grp.push_back(dest_pix(low_src & m, 1'b1));
    end
    if (grp.size() != 0) begin
      grp[grp.size() - 1].last = 1'b1;
    end
    foreach (grp[i]) pending_pix_q.push_back(grp[i]);
    prev_upper_shadow = up;
    prev_lower_shadow = lo;
    prev_valid_shadow = !row_end;
  endtask

  // ---------------------------------------------------------------------------
  // Checking: every output transfer is compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dest_pix_t exp_pix;
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixel_cnt <= pixel_cnt + 1;
      if (pending_pix_q.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected output pixel %h row %0b last %0b", $time,
                 out_pixel_o, dest_row_o, run_last_o);
      end else begin
        exp_pix = pending_pix_q.pop_front();
        if (out_pixel_o !== exp_pix.pix) begin
          error_cnt++;
          $display("%0t: out_pixel expected %h actual %h", $time, exp_pix.pix, out_pixel_o);
        end
        if (dest_row_o !== exp_pix.row) begin
          error_cnt++;
          $display("%0t: dest_row expected %0b actual %0b", $time, exp_pix.row, dest_row_o);
        end
        if (run_last_o !== exp_pix.last) begin
          error_cnt++;
          $display("%0t: run_last expected %0b actual %0b", $time, exp_pix.last,
                   run_last_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each output transfer it draws a random stall while idling is on.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        stall_left = idle_on ? $urandom_range(0, MaxIdle) : 0;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_ready_i <= (stall_left == 0) && !hold_off;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------

  // Offers one column and returns at the edge where the transfer happens.
  task automatic send_column(input logic [PixW-1:0] up, input logic [PixW-1:0] lo,
                             input logic row_end, input logic bottom);
    if (!valid_held) begin
      repeat (next_gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    upper_pixel_i <= up;
    lower_pixel_i <= lo;
    row_end_i     <= row_end;
    bottom_row_i  <= bottom;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    upscale_column(up, lo, row_end, bottom);
    column_cnt++;
    // A zero gap keeps valid high so that the next column follows at once.
    next_gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (next_gap != 0) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end else begin
      valid_held = 1'b1;
    end
  endtask

  // Ends a burst: drops valid, waits for every owed pixel and lets the block
  // settle, since a first column of a row leaves no pixel to wait for.
  task automatic drain_block();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    next_gap = 1;
    while (pending_pix_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write of the format register: setup cycle, then access cycle.
  task automatic write_format(input logic [FmtW-1:0] code);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegPixelFormat;
    pwdata  <= {29'($urandom()), code};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    fmt_shadow = code;
  endtask

  // Random pixel with the all-zero and all-one corners drawn often.
  function automatic logic [PixW-1:0] rand_pix();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset format is RGB565: a single-column row, a plain row and a bottom row.
  task automatic test_reset_format();
    send_column(32'h1234_F81F, 32'h0000_07E0, 1'b1, 1'b0);
    send_column(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
    send_column(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_column(32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b1, 1'b0);
    send_column(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
    send_column(32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1);
    drain_block();
  endtask

  // Each format code but RGB565, and two of the unknown ones, on a two-column
  // row of opposite extremes, plus a bottom row in RGB888.
  task automatic test_each_format();
    logic [FmtW-1:0] codes[6];
    codes = '{FMT_DUP, FMT_555, FMT_888, FMT_8888, FmtSpareLo, FmtSpareHi};
    foreach (codes[i]) begin
      write_format(codes[i]);
      send_column(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      send_column(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      drain_block();
    end
    write_format(FMT_888);
    send_column(32'h80FF_01FE, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_column(32'h7F00_FF01, 32'h0000_0000, 1'b1, 1'b1);
    drain_block();
  endtask

  // Random phases, one per entry of a code list that repeats RGB565. Most
  // items form proper rows whose bottom flag seldom flips; the rest are
  // broken rows with random row ends and bottom flags that vary in the row.
  task automatic test_random_rows();
    logic [FmtW-1:0] codes[8];
    int unsigned     sent;
    int unsigned     len;
    logic            bot;
    logic            noisy;
    codes = '{FMT_565, FMT_DUP, FMT_8888, FMT_555, FmtSpareMid, FMT_888,
              FmtSpareHi, FMT_565};
    foreach (codes[p]) begin
      write_format(codes[p]);
      idle_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 35) begin
        len   = $urandom_range(1, 6);
        bot   = ($urandom_range(0, 3) == 0);
        noisy = ($urandom_range(0, 6) == 0);
        for (int unsigned c = 0; c < len; c++) begin
          if (noisy) begin
            send_column(rand_pix(), rand_pix(), 1'($urandom()), 1'($urandom()));
          end else begin
            if ($urandom_range(0, 9) == 0) bot = !bot;
            send_column(rand_pix(), rand_pix(), c == len - 1, bot);
          end
          sent++;
        end
        // Occasionally switch between idling and a flat-out stretch.
        if ($urandom_range(0, 4) == 0) idle_on = !idle_on;
      end
      drain_block();
    end
    idle_on = 1'b1;
  endtask

  // The receiver stalls for a long stretch while columns keep coming, so the
  // result buffer fills and the block must hold off its input.
  task automatic test_output_backpressure();
    write_format(FMT_888);
    idle_on = 1'b0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    for (int unsigned i = 0; i < 12; i++) begin
      send_column($urandom(), $urandom(), (i % 3) == 2, i >= 9);
    end
    drain_block();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_format();
    test_each_format();
    test_random_rows();
    test_output_backpressure();

    $display("Run covered %0d input transfers and %0d output transfers over all format codes,",
             column_cnt, pixel_cnt);
    $display("with single-column, bottom and broken rows, random idling and a long output stall.");
    if (error_cnt == 0 && pending_pix_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rpd_pkg.sv
rtl/core/rpd_avg_lane.sv
rtl/core/rpd_merge.sv
rtl/core/rgb_pixel_doubler_interp.sv
bench/tb_rgb_pixel_doubler_interp.sv
